// ===== rtl/prpc_pkg.sv =====
`timescale 1ns / 1ps

package prpc_pkg;

    // Fixed-point format of the trig registers and model coordinates.
    localparam int FRAC_BITS = 14;

    localparam int W_COORD  = 16;
    localparam int W_TRIG   = 16;
    localparam int W_SCALE  = 10;
    localparam int W_CENTER = 11;
    localparam int W_BYTE   = 8;

    // Depth term is rotated z times 16.
    localparam int DEPTH_SHIFT = 4;
    localparam int DEPTH_BIAS  = 15;
    localparam int DEPTH_MIN   = -7;
    localparam int SCREEN_W    = 240;
    localparam int SCREEN_H    = 160;

    // Widths of the intermediate values, all kept exact.
    localparam int W_P0 = W_COORD + W_TRIG;          // first rotation product
    localparam int W_F0 = W_P0 - FRAC_BITS;          // after floor shift
    localparam int W_R  = W_F0 + 1;                  // rotated x and z about Y
    localparam int W_P1 = W_R + W_TRIG;              // second rotation product
    localparam int W_F1 = W_P1 - FRAC_BITS;
    localparam int W_O  = ((W_F1 > W_F0) ? W_F1 : W_F0) + 1;  // y and z after X
    localparam int W_PX = W_R + W_SCALE + 1;         // scaled x product
    localparam int W_PY = W_O + W_SCALE + 1;         // scaled y product
    localparam int W_COL = W_PX + 1;
    localparam int W_ROW = W_PY + 1;
    localparam int W_DZ  = W_O + DEPTH_SHIFT;

    localparam int N_STAGES = 6;

    localparam int W_CFG_IDX  = 3;
    localparam int W_CFG_DATA = 16;

    typedef enum logic [W_CFG_IDX-1:0] {
        REG_SIN_X        = 3'd0,
        REG_COS_X        = 3'd1,
        REG_SIN_Y        = 3'd2,
        REG_COS_Y        = 3'd3,
        REG_SCALE_FACTOR = 3'd4,
        REG_CENTER_COL   = 3'd5,
        REG_CENTER_ROW   = 3'd6
    } t_cfg_reg;

    localparam logic signed [W_TRIG-1:0]   RST_SIN    = 16'sd0;
    localparam logic signed [W_TRIG-1:0]   RST_COS    = 16'sd16384;
    localparam logic        [W_SCALE-1:0]  RST_SCALE  = 10'd64;
    localparam logic signed [W_CENTER-1:0] RST_CEN_C  = 11'sd120;
    localparam logic signed [W_CENTER-1:0] RST_CEN_R  = 11'sd80;

endpackage

// ===== rtl/point_rotate_project_clip.sv =====
`timescale 1ns / 1ps

// Rotates a stream of Q1.14 model points about Y and then X and projects them
// onto a 240x160 screen. One point is accepted per clock unless back pressure
// has filled every stage. A result becomes valid on the output once its point
// has passed through all six register stages of the multiply chain, which is
// three rotation/scale multiplies deep, and is held there until it is taken.
// Each stage holds a valid bit and only stalls when the stage after it is full
// and blocked, so bubbles close up under back pressure. The trig, scale and
// center registers are read live by the pipeline and must only be written
// while no point is in flight. Output tdata carries screen x, screen y and the
// depth code; tuser carries the visible flag, computed on the full values.
module point_rotate_project_clip
    import prpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] point_x, [31:16] point_y, [47:32] point_z
    input  logic [3*W_COORD-1:0]  s_axis_tdata,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] screen_x, [15:8] screen_y, [23:16] depth_code
    output logic [3*W_BYTE-1:0]   m_axis_tdata,
    // [0] visible
    output logic                  m_axis_tuser,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [W_CFG_IDX-1:0]  i_cfg_index,
    input  logic [W_CFG_DATA-1:0] i_cfg_data
);

    // Configuration registers.
    logic signed [W_TRIG-1:0]   r_sin_x, r_cos_x, r_sin_y, r_cos_y;
    logic        [W_SCALE-1:0]  r_scale;
    logic signed [W_CENTER-1:0] r_cen_c, r_cen_r;

    // Nothing is taken while reset is held.
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin_x <= RST_SIN;
            r_cos_x <= RST_COS;
            r_sin_y <= RST_SIN;
            r_cos_y <= RST_COS;
            r_scale <= RST_SCALE;
            r_cen_c <= RST_CEN_C;
            r_cen_r <= RST_CEN_R;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_SIN_X:        r_sin_x <= i_cfg_data[W_TRIG-1:0];
                REG_COS_X:        r_cos_x <= i_cfg_data[W_TRIG-1:0];
                REG_SIN_Y:        r_sin_y <= i_cfg_data[W_TRIG-1:0];
                REG_COS_Y:        r_cos_y <= i_cfg_data[W_TRIG-1:0];
                REG_SCALE_FACTOR: r_scale <= i_cfg_data[W_SCALE-1:0];
                REG_CENTER_COL:   r_cen_c <= i_cfg_data[W_CENTER-1:0];
                REG_CENTER_ROW:   r_cen_r <= i_cfg_data[W_CENTER-1:0];
                default: ;
            endcase
        end
    end

    // Stage valid bits and load enables. A stage loads when it is empty or
    // when the stage after it is loading this cycle.
    logic [N_STAGES-1:0] r_v;
    logic [N_STAGES-1:0] ld;

    always_comb begin
        ld[N_STAGES-1] = !r_v[N_STAGES-1] || m_axis_tready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            ld[k] = !r_v[k] || ld[k+1];
        end
    end

    assign s_axis_tready = i_rst_n && ld[0];
    assign m_axis_tvalid = r_v[N_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ld[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (ld[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    logic signed [W_COORD-1:0] in_x, in_y, in_z;
    assign in_x = s_axis_tdata[W_COORD-1:0];
    assign in_y = s_axis_tdata[2*W_COORD-1:W_COORD];
    assign in_z = s_axis_tdata[3*W_COORD-1:2*W_COORD];

    // Stage 1: the six first-level products, floor shifted.
    logic signed [W_P0-1:0] p_xcy, p_zsy, p_zcy, p_xsy, p_ycx, p_ysx;
    logic signed [W_F0-1:0] r1_xcy, r1_zsy, r1_zcy, r1_xsy, r1_ycx, r1_ysx;

    assign p_xcy = W_P0'(in_x) * W_P0'(r_cos_y);
    assign p_zsy = W_P0'(in_z) * W_P0'(r_sin_y);
    assign p_zcy = W_P0'(in_z) * W_P0'(r_cos_y);
    assign p_xsy = W_P0'(in_x) * W_P0'(r_sin_y);
    assign p_ycx = W_P0'(in_y) * W_P0'(r_cos_x);
    assign p_ysx = W_P0'(in_y) * W_P0'(r_sin_x);

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r1_xcy <= W_F0'(p_xcy >>> FRAC_BITS);
            r1_zsy <= W_F0'(p_zsy >>> FRAC_BITS);
            r1_zcy <= W_F0'(p_zcy >>> FRAC_BITS);
            r1_xsy <= W_F0'(p_xsy >>> FRAC_BITS);
            r1_ycx <= W_F0'(p_ycx >>> FRAC_BITS);
            r1_ysx <= W_F0'(p_ysx >>> FRAC_BITS);
        end
    end

    // Stage 2: rotation about Y.
    logic signed [W_R-1:0]  r2_xr, r2_zr;
    logic signed [W_F0-1:0] r2_ycx, r2_ysx;

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r2_xr  <= W_R'(r1_xcy) + W_R'(r1_zsy);
            r2_zr  <= W_R'(r1_zcy) - W_R'(r1_xsy);
            r2_ycx <= r1_ycx;
            r2_ysx <= r1_ysx;
        end
    end

    // Stage 3: second-level products and the x scale product.
    logic signed [W_P1-1:0] r3_pzs, r3_pzc;
    logic signed [W_PX-1:0] r3_pxs;
    logic signed [W_F0-1:0] r3_ycx, r3_ysx;

    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r3_pzs <= W_P1'(r2_zr) * W_P1'(r_sin_x);
            r3_pzc <= W_P1'(r2_zr) * W_P1'(r_cos_x);
            r3_pxs <= W_PX'(r2_xr) * W_PX'($signed({1'b0, r_scale}));
            r3_ycx <= r2_ycx;
            r3_ysx <= r2_ysx;
        end
    end

    // Stage 4: rotation about X and the projected column.
    // Truncation toward zero adds the fraction mask to negative values first.
    logic signed [W_PX-1:0] tr_x;
    logic signed [W_O-1:0]  r4_yo, r4_zo;
    logic signed [W_COL-1:0] r4_col;

    assign tr_x = $signed(r3_pxs + {{(W_PX-FRAC_BITS){1'b0}}, {FRAC_BITS{r3_pxs[W_PX-1]}}})
                  >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (ld[3]) begin
            r4_yo  <= W_O'(r3_ycx) - W_O'(W_F1'(r3_pzs >>> FRAC_BITS));
            r4_zo  <= W_O'(r3_ysx) + W_O'(W_F1'(r3_pzc >>> FRAC_BITS));
            r4_col <= W_COL'(r_cen_c) + W_COL'(tr_x);
        end
    end

    // Stage 5: y scale product and the depth term.
    logic signed [W_DZ-1:0]  dz;
    logic signed [W_DZ-1:0]  tr_d;
    logic signed [W_PY-1:0]  r5_pys;
    logic signed [W_DZ-1:0]  r5_dep;
    logic signed [W_COL-1:0] r5_col;

    assign dz   = $signed({r4_zo, {DEPTH_SHIFT{1'b0}}});
    assign tr_d = $signed(dz + {{(W_DZ-FRAC_BITS){1'b0}}, {FRAC_BITS{dz[W_DZ-1]}}})
                  >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r5_pys <= W_PY'(r4_yo) * W_PY'($signed({1'b0, r_scale}));
            r5_dep <= tr_d;
            r5_col <= r4_col;
        end
    end

    // Stage 6: projected row, clipping and output word.
    logic signed [W_PY-1:0]  tr_y;
    logic signed [W_ROW-1:0] row;
    logic                    vis;
    logic [W_BYTE-1:0]       r_sx, r_sy, r_dc;
    logic                    r_vis;

    assign tr_y = $signed(r5_pys + {{(W_PY-FRAC_BITS){1'b0}}, {FRAC_BITS{r5_pys[W_PY-1]}}})
                  >>> FRAC_BITS;
    assign row  = W_ROW'(r_cen_r) + W_ROW'(tr_y);

    always_comb begin
        vis = !r5_col[W_COL-1] && (r5_col < W_COL'(SCREEN_W))
              && !row[W_ROW-1] && (row < W_ROW'(SCREEN_H))
              && (r5_dep >= W_DZ'(DEPTH_MIN));
    end

    always_ff @(posedge i_clk) begin
        if (ld[5]) begin
            r_sx  <= r5_col[W_BYTE-1:0];
            r_sy  <= row[W_BYTE-1:0];
            r_dc  <= W_BYTE'(r5_dep + W_DZ'(DEPTH_BIAS));
            r_vis <= vis;
        end
    end

    assign m_axis_tdata = {r_dc, r_sy, r_sx};
    assign m_axis_tuser = r_vis;

endmodule

// ===== tb/tb_point_rotate_project_clip.sv =====
`timescale 1ns / 1ps

module tb_point_rotate_project_clip;
    import prpc_pkg::*;

    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int RANDOM_PHASES    = 10;
    localparam int POINTS_PER_PHASE = 125;
    // Register index with no register behind it; the block drops such writes.
    localparam logic [W_CFG_IDX-1:0] CFG_IDX_UNUSED = 3'd7;

    typedef struct packed {
        logic [W_BYTE-1:0] scr_x;
        logic [W_BYTE-1:0] scr_y;
        logic [W_BYTE-1:0] depth_code;
        logic              visible;
    } t_pixel;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [3*W_COORD-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [3*W_BYTE-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [W_CFG_IDX-1:0]  i_cfg_index = '0;
    logic [W_CFG_DATA-1:0] i_cfg_data = '0;

    // Shadow copy of the configuration registers.
    logic signed [W_TRIG-1:0]   rot_sin_x = RST_SIN;
    logic signed [W_TRIG-1:0]   rot_cos_x = RST_COS;
    logic signed [W_TRIG-1:0]   rot_sin_y = RST_SIN;
    logic signed [W_TRIG-1:0]   rot_cos_y = RST_COS;
    logic        [W_SCALE-1:0]  pix_scale = RST_SCALE;
    logic signed [W_CENTER-1:0] ctr_col   = RST_CEN_C;
    logic signed [W_CENTER-1:0] ctr_row   = RST_CEN_R;

    logic [3*W_COORD-1:0] point_queue[$];
    t_pixel               expected_pixels[$];

    int  points_queued   = 0;
    int  points_accepted = 0;
    int  results_seen    = 0;
    int  mismatch_count  = 0;
    int  send_idle       = 0;
    int  recv_stall      = 0;
    int  quiet_cycles    = 0;
    bit  burst_mode      = 1'b0;
    t_pixel got_pixel;
    t_pixel want_pixel;

    point_rotate_project_clip dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint floor_q(input longint v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic longint trunc_q(input longint v);
        if (v < 0) begin
            return -((-v) >>> FRAC_BITS);
        end
        return v >>> FRAC_BITS;
    endfunction

    function automatic t_pixel project_point(input logic [3*W_COORD-1:0] word);
        longint px, py, pz, sx, cx, sy, cy, sc;
        longint xr, zr, yo, zo, col, row, dep;
        t_pixel p;
        px = longint'($signed(word[W_COORD-1:0]));
        py = longint'($signed(word[2*W_COORD-1:W_COORD]));
        pz = longint'($signed(word[3*W_COORD-1:2*W_COORD]));
        sx = longint'(rot_sin_x);
        cx = longint'(rot_cos_x);
        sy = longint'(rot_sin_y);
        cy = longint'(rot_cos_y);
        sc = longint'(pix_scale);
        xr = floor_q(px * cy) + floor_q(pz * sy);
        zr = floor_q(pz * cy) - floor_q(px * sy);
        yo = floor_q(py * cx) - floor_q(zr * sx);
        zo = floor_q(py * sx) + floor_q(zr * cx);
        col = longint'(ctr_col) + trunc_q(xr * sc);
        row = longint'(ctr_row) + trunc_q(yo * sc);
        dep = trunc_q(zo * longint'(1 << DEPTH_SHIFT));
        p.scr_x      = col[W_BYTE-1:0];
        p.scr_y      = row[W_BYTE-1:0];
        p.depth_code = W_BYTE'(dep + longint'(DEPTH_BIAS));
        p.visible    = (col >= 0) && (col < longint'(SCREEN_W))
                       && (row >= 0) && (row < longint'(SCREEN_H))
                       && (dep >= longint'(DEPTH_MIN));
        return p;
    endfunction

    task automatic apply_reg(input logic [W_CFG_IDX-1:0] idx,
                             input logic [W_CFG_DATA-1:0] data);
        case (idx)
            REG_SIN_X:        rot_sin_x = data;
            REG_COS_X:        rot_cos_x = data;
            REG_SIN_Y:        rot_sin_y = data;
            REG_COS_Y:        rot_cos_y = data;
            REG_SCALE_FACTOR: pix_scale = data[W_SCALE-1:0];
            REG_CENTER_COL:   ctr_col   = data[W_CENTER-1:0];
            REG_CENTER_ROW:   ctr_row   = data[W_CENTER-1:0];
            default: ;
        endcase
    endtask

    // Called at a rising edge. Leaves valid high so back-to-back writes need
    // no second assignment in one step; the caller lowers it after the last.
    task automatic cfg_write(input logic [W_CFG_IDX-1:0] idx,
                             input logic [W_CFG_DATA-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      results_seen, name, got, want));
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (burst_mode) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [3*W_COORD-1:0] pack_point(input int x, input int y, input int z);
        return {W_COORD'(z), W_COORD'(y), W_COORD'(x)};
    endfunction

    function automatic int rand_coord(input int mode);
        if (mode < 20) begin
            return $urandom;
        end
        if (mode < 70) begin
            return int'($urandom_range(0, 32768)) - 16384;
        end
        return int'($urandom_range(0, 8192)) - 4096;
    endfunction

    function automatic logic [W_CFG_DATA-1:0] rand_trig();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1:    return W_CFG_DATA'($urandom);
            2:       return W_CFG_DATA'(16384);
            3:       return W_CFG_DATA'(-16384);
            4:       return '0;
            default: return W_CFG_DATA'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic [W_CFG_DATA-1:0] rand_center();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            return W_CFG_DATA'($urandom);
        end
        if (r < 7) begin
            return W_CFG_DATA'($urandom_range(0, 240));
        end
        return W_CFG_DATA'(int'($urandom_range(0, 2047)) - 1024);
    endfunction

    function automatic logic [W_CFG_DATA-1:0] rand_scale();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            return W_CFG_DATA'($urandom);
        end
        if (r < 8) begin
            return W_CFG_DATA'($urandom_range(0, 160));
        end
        return W_CFG_DATA'($urandom_range(0, 1023));
    endfunction

    task automatic queue_point(input logic [3*W_COORD-1:0] word);
        point_queue.push_back(word);
        points_queued++;
    endtask

    task automatic queue_random_points(input int count);
        for (int i = 0; i < count; i++) begin
            queue_point(pack_point(rand_coord($urandom_range(0, 99)),
                                   rand_coord($urandom_range(0, 99)),
                                   rand_coord($urandom_range(0, 99))));
        end
    endtask

    task automatic wait_drained();
        while (points_accepted != points_queued || expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Sender: one word per handshake, with random gaps between words.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_pixels.push_back(project_point(s_axis_tdata));
                points_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_idle > 0) begin
                    send_idle--;
                    s_axis_tvalid <= 1'b0;
                end else if (point_queue.size() != 0) begin
                    s_axis_tdata  <= point_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    send_idle = pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result word and stalls at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_pixel.scr_x      = m_axis_tdata[W_BYTE-1:0];
                got_pixel.scr_y      = m_axis_tdata[2*W_BYTE-1:W_BYTE];
                got_pixel.depth_code = m_axis_tdata[3*W_BYTE-1:2*W_BYTE];
                got_pixel.visible    = m_axis_tuser;
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_seen));
                end else begin
                    want_pixel = expected_pixels.pop_front();
                    check_field("screen_x", int'(got_pixel.scr_x), int'(want_pixel.scr_x));
                    check_field("screen_y", int'(got_pixel.scr_y), int'(want_pixel.scr_y));
                    check_field("depth_code", int'(got_pixel.depth_code),
                                int'(want_pixel.depth_code));
                    check_field("visible", int'(got_pixel.visible),
                                int'(want_pixel.visible));
                end
                results_seen++;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                recv_stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_point_rotate_project_clip failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings make the rotation an identity, so screen edges,
        // rounding toward zero and the depth limit can be hit exactly.
        queue_point(pack_point(0, 0, 0));
        queue_point(pack_point(16384, 16384, 16384));
        queue_point(pack_point(-16384, -16384, -16384));
        queue_point(pack_point(32767, 32767, 32767));
        queue_point(pack_point(-32768, -32768, -32768));
        queue_point(pack_point(-30720, 0, 0));
        queue_point(pack_point(-30976, 0, 0));
        queue_point(pack_point(30464, 0, 0));
        queue_point(pack_point(30720, 0, 0));
        queue_point(pack_point(0, -20480, 0));
        queue_point(pack_point(0, -20736, 0));
        queue_point(pack_point(0, 20224, 0));
        queue_point(pack_point(0, 20480, 0));
        queue_point(pack_point(-255, -255, -1023));
        queue_point(pack_point(0, 0, -7168));
        queue_point(pack_point(0, 0, -8191));
        queue_point(pack_point(0, 0, -8192));
        wait_drained();

        cfg_write(REG_SIN_X, W_CFG_DATA'(16384));
        cfg_write(REG_COS_X, W_CFG_DATA'(-16384));
        cfg_write(REG_SIN_Y, W_CFG_DATA'(-16384));
        cfg_write(REG_COS_Y, W_CFG_DATA'(16384));
        cfg_write(REG_SCALE_FACTOR, W_CFG_DATA'(1023));
        cfg_write(REG_CENTER_COL, W_CFG_DATA'(1023));
        cfg_write(REG_CENTER_ROW, W_CFG_DATA'(-1024));
        cfg_write(CFG_IDX_UNUSED, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        queue_random_points(60);
        wait_drained();

        // Full-scale trig values and a scale word whose upper bits must be dropped.
        cfg_write(REG_SIN_X, 16'h8000);
        cfg_write(REG_COS_X, 16'h7FFF);
        cfg_write(REG_SIN_Y, 16'h7FFF);
        cfg_write(REG_COS_Y, 16'h8000);
        cfg_write(REG_SCALE_FACTOR, 16'hFC00);
        cfg_write(REG_CENTER_COL, W_CFG_DATA'(-1024));
        cfg_write(REG_CENTER_ROW, W_CFG_DATA'(1023));
        i_cfg_valid <= 1'b0;
        queue_random_points(60);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            burst_mode = (phase % 4 == 1);
            cfg_write(REG_SIN_X, rand_trig());
            cfg_write(REG_COS_X, rand_trig());
            cfg_write(REG_SIN_Y, rand_trig());
            cfg_write(REG_COS_Y, rand_trig());
            cfg_write(REG_SCALE_FACTOR, rand_scale());
            cfg_write(REG_CENTER_COL, rand_center());
            cfg_write(REG_CENTER_ROW, rand_center());
            if ($urandom_range(0, 2) == 0) begin
                cfg_write(CFG_IDX_UNUSED, W_CFG_DATA'($urandom));
            end
            i_cfg_valid <= 1'b0;
            if (phase == 3) begin
                // Let the pipeline empty completely before the rest of the phase.
                queue_random_points(POINTS_PER_PHASE / 2);
                wait_drained();
                queue_random_points(POINTS_PER_PHASE - POINTS_PER_PHASE / 2);
            end else begin
                queue_random_points(POINTS_PER_PHASE);
            end
            wait_drained();
        end

        repeat (N_STAGES + 4) @(posedge i_clk);
        if (expected_pixels.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
        end
        if (mismatch_count == 0) begin
            $display("tb_point_rotate_project_clip passed");
        end else begin
            $display("tb_point_rotate_project_clip failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/prpc_pkg.sv
rtl/point_rotate_project_clip.sv
tb/tb_point_rotate_project_clip.sv
